// ===== rtl/pfa_pkg.sv =====
`default_nettype none

package pfa_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Fixed field widths of the stream items
  localparam int IDX_FIELD_W  = 4;
  localparam int AMT_W        = 16;
  localparam int FREE_W       = 20;
  localparam int TALLY_W      = 24;
  localparam int FRAG_W       = 2;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 72;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int BCOUNT_W     = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 4'd1;

  localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

  // Saturation limits
  localparam logic [FREE_W-1:0]  FREE_MAX  = 20'hFFFFF;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 24'hFFFFFF;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Fragmentation verdicts
  localparam logic [FRAG_W-1:0] FRAG_NONE     = 2'd0;
  localparam logic [FRAG_W-1:0] FRAG_EXTERNAL = 2'd1;
  localparam logic [FRAG_W-1:0] FRAG_SHORT    = 2'd2;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } fit_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift_en;
    logic wr_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/pfa_cell.sv =====
`default_nettype none

// One partition cell of the ring: holds a remaining size, takes its
// neighbor's value on a shift, or a new value on a direct write.
module pfa_cell #(
  parameter int WIDTH = pfa_pkg::SIZE_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire pfa_pkg::cell_ctl_t ctl,
  input  wire  [WIDTH-1:0]        shift_in,
  input  wire  [WIDTH-1:0]        wr_val,
  output logic [WIDTH-1:0]        val_out
);

  logic [WIDTH-1:0] val_r;
  logic [WIDTH-1:0] val_nxt;

  // write wins; shift and write never coincide
  always_comb begin
    val_nxt = val_r;
    if (ctl.wr_en) begin
      val_nxt = wr_val;
    end else if (ctl.shift_en) begin
      val_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val_out = val_r;

endmodule

`default_nettype wire

// ===== rtl/partition_fit_allocator.sv =====
`default_nettype none

// Channel   Dir  Handshake              Payload
// in_*      in   in_tvalid/in_tready    tdata {amount, block_index}, tuser command,
//                                       tlast final_request
// out_*     out  out_tvalid/out_tready  tdata {frag, tally, free, left, chosen},
//                                       tuser granted
// cfg_*     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Every item, load or allocate, passes through an accept step, a scan that
// rotates the ring of partition cells once past the head cell, where the fit
// choice and the free-space sum are formed, and a commit step.
// The commit waits while a previous result sits unread in the output register.
// Synchronous reset clears all cells, the pointer and the tally.
module partition_fit_allocator #(
  parameter int MAX_BLOCKS = pfa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // bits [3:0] block_index, [19:4] amount, [23:20] zero
  input  wire  [pfa_pkg::IN_DATA_W-1:0]     in_tdata,
  // bit 0 command
  input  wire                               in_tuser,
  input  wire                               in_tlast,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // bits [3:0] chosen_block, [19:4] block_left, [39:20] total_free,
  // [63:40] unplaced_total, [65:64] frag_status, [71:66] zero
  output logic [pfa_pkg::OUT_DATA_W-1:0]    out_tdata,
  // bit 0 granted
  output logic                              out_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  input  wire  [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pfa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready
);

  localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W   = (SIZE_BITS > pfa_pkg::AMT_W) ? SIZE_BITS : pfa_pkg::AMT_W;
  localparam int SUM_W   = SIZE_BITS + CNT_W;
  localparam int WIDE_W  = (SUM_W > pfa_pkg::TALLY_W + 1) ? SUM_W : pfa_pkg::TALLY_W + 1;

  // Input field split
  logic [pfa_pkg::IDX_FIELD_W-1:0] in_bidx;
  logic [pfa_pkg::AMT_W-1:0]       in_amount;
  assign in_bidx   = in_tdata[3:0];
  assign in_amount = in_tdata[19:4];

  // Configuration registers
  pfa_pkg::fit_mode_t             fit_mode_r;
  logic [pfa_pkg::BCOUNT_W-1:0]   block_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= pfa_pkg::FIT_FIRST;
      block_count_r <= pfa_pkg::BLOCK_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pfa_pkg::CFG_FIT_MODE) begin
        fit_mode_r <= pfa_pkg::fit_mode_t'(cfg_data[1:0]);
      end else if (cfg_index == pfa_pkg::CFG_BLOCK_COUNT) begin
        block_count_r <= cfg_data[pfa_pkg::BCOUNT_W-1:0];
      end
    end
  end

  // Partitions in use, clamped to 1..MAX_BLOCKS
  logic [CNT_W-1:0] used_cnt;
  always_comb begin
    if (block_count_r == '0) begin
      used_cnt = CNT_W'(1);
    end else if (32'(block_count_r) > MAX_BLOCKS) begin
      used_cnt = CNT_W'(MAX_BLOCKS);
    end else begin
      used_cnt = CNT_W'(block_count_r);
    end
  end

  // Sequencer state and item registers
  pfa_pkg::state_t              st_r, st_nxt;
  logic                         cmd_r;
  logic                         final_r;
  logic [pfa_pkg::AMT_W-1:0]    amt_r;
  logic [pfa_pkg::IDX_FIELD_W-1:0] bidx_r;
  logic [pfa_pkg::AMT_W-1:0]    load_left_r;
  logic [CNT_W-1:0]             k_r;
  logic [IDX_W-1:0]             start_r;
  logic                         found_r;
  logic [IDX_W-1:0]             pick_r;
  logic [SIZE_BITS-1:0]         pick_val_r;
  logic [SUM_W-1:0]             sum_r;
  logic [IDX_W-1:0]             ptr_r;
  logic [pfa_pkg::TALLY_W-1:0]  tally_r;

  logic                         out_valid_r;
  logic                         accept;
  logic                         scan_step;
  logic                         fire;
  logic                         scan_last;

  assign scan_last = (k_r == CNT_W'(MAX_BLOCKS - 1));

  // Next state and handshake
  always_comb begin
    st_nxt    = st_r;
    in_tready = 1'b0;
    scan_step = 1'b0;
    fire      = 1'b0;
    case (st_r)
      pfa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          st_nxt = pfa_pkg::ST_SCAN;
        end
      end
      pfa_pkg::ST_SCAN: begin
        scan_step = 1'b1;
        if (scan_last) begin
          st_nxt = pfa_pkg::ST_FIN;
        end
      end
      pfa_pkg::ST_FIN: begin
        fire = !out_valid_r || out_tready;
        if (fire) begin
          st_nxt = pfa_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = pfa_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pfa_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Load value masked to the cell width
  logic [CMP_W-1:0]     ld_wide;
  logic [SIZE_BITS-1:0] ld_val;
  logic [CMP_W-1:0]     ld_back;
  logic                 ld_ok;
  assign ld_wide = CMP_W'(in_amount);
  assign ld_val  = ld_wide[SIZE_BITS-1:0];
  assign ld_back = CMP_W'(ld_val);
  assign ld_ok   = (32'(in_bidx) < MAX_BLOCKS);

  // Remainder of the chosen partition
  logic [CMP_W-1:0] rem_wide;
  assign rem_wide = CMP_W'(pick_val_r) - CMP_W'(amt_r);

  // Ring of partition cells; cell 0 is the head seen by the scan
  logic [SIZE_BITS-1:0]  cell_val [MAX_BLOCKS];
  pfa_pkg::cell_ctl_t    cell_ctl [MAX_BLOCKS];
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [SIZE_BITS-1:0]  wr_val;

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = IDX_W'(in_bidx);
    wr_val = ld_val;
    if (accept && in_tuser == pfa_pkg::CMD_LOAD && ld_ok) begin
      wr_en = 1'b1;
    end else if (fire && cmd_r == pfa_pkg::CMD_ALLOC && found_r) begin
      wr_en  = 1'b1;
      wr_idx = pick_r;
      wr_val = rem_wide[SIZE_BITS-1:0];
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
      localparam int NEIGHBOR = (gi + 1) % MAX_BLOCKS;
      assign cell_ctl[gi].shift_en = scan_step;
      assign cell_ctl[gi].wr_en    = wr_en && (wr_idx == IDX_W'(gi));
      pfa_cell #(
        .WIDTH (SIZE_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl[gi]),
        .shift_in (cell_val[NEIGHBOR]),
        .wr_val   (wr_val),
        .val_out  (cell_val[gi])
      );
    end
  endgenerate

  // Fit decision on the head cell
  logic [SIZE_BITS-1:0] head;
  logic [IDX_W-1:0]     head_idx;
  logic                 head_used;
  logic                 head_fits;
  logic                 take;
  assign head      = cell_val[0];
  assign head_idx  = k_r[IDX_W-1:0];
  assign head_used = (k_r < used_cnt);
  assign head_fits = head_used && (CMP_W'(head) >= CMP_W'(amt_r));

  always_comb begin
    case (fit_mode_r)
      pfa_pkg::FIT_FIRST: take = !found_r;
      pfa_pkg::FIT_NEXT:  take = !found_r || (head_idx >= start_r && pick_r < start_r);
      pfa_pkg::FIT_BEST:  take = !found_r || (head < pick_val_r);
      pfa_pkg::FIT_WORST: take = !found_r || (head > pick_val_r);
      default:            take = 1'b0;
    endcase
    take = take && head_fits;
  end

  // Next-fit starting point
  logic [IDX_W-1:0] start_nxt;
  assign start_nxt = (CNT_W'(ptr_r) < used_cnt) ? ptr_r : '0;

  // Item registers and scan accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_tuser;
      final_r     <= in_tlast;
      amt_r       <= in_amount;
      bidx_r      <= in_bidx;
      load_left_r <= ld_ok ? ld_back[pfa_pkg::AMT_W-1:0] : '0;
      start_r     <= start_nxt;
      k_r         <= '0;
      sum_r       <= '0;
      found_r     <= 1'b0;
      pick_r      <= '0;
      pick_val_r  <= '0;
    end else if (scan_step) begin
      k_r <= k_r + CNT_W'(1);
      if (head_used) begin
        sum_r <= sum_r + SUM_W'(head);
      end
      if (take) begin
        found_r    <= 1'b1;
        pick_r     <= head_idx;
        pick_val_r <= head;
      end
    end
  end

  // Results of the commit step
  logic                         granted;
  logic [SUM_W-1:0]             sum_fin;
  logic [WIDE_W-1:0]            sum_wide;
  logic [pfa_pkg::TALLY_W:0]    tally_add;
  logic [pfa_pkg::TALLY_W-1:0]  tally_nxt;
  logic [pfa_pkg::FRAG_W-1:0]   frag;
  logic [pfa_pkg::FREE_W-1:0]   free_sat;

  assign granted   = (cmd_r == pfa_pkg::CMD_ALLOC) && found_r;
  assign sum_fin   = granted ? (sum_r - SUM_W'(amt_r)) : sum_r;
  assign sum_wide  = WIDE_W'(sum_fin);
  assign tally_add = {1'b0, tally_r} + (pfa_pkg::TALLY_W + 1)'(amt_r);

  always_comb begin
    tally_nxt = tally_r;
    if (cmd_r == pfa_pkg::CMD_ALLOC && !found_r) begin
      tally_nxt = tally_add[pfa_pkg::TALLY_W] ? pfa_pkg::TALLY_MAX
                                              : tally_add[pfa_pkg::TALLY_W-1:0];
    end
  end

  always_comb begin
    if (tally_nxt == '0) begin
      frag = pfa_pkg::FRAG_NONE;
    end else if (sum_wide >= WIDE_W'(tally_nxt)) begin
      frag = pfa_pkg::FRAG_EXTERNAL;
    end else begin
      frag = pfa_pkg::FRAG_SHORT;
    end
  end

  assign free_sat = (sum_wide > WIDE_W'(pfa_pkg::FREE_MAX)) ? pfa_pkg::FREE_MAX
                                                             : sum_wide[pfa_pkg::FREE_W-1:0];

  // Pointer and tally
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      tally_r <= '0;
    end else if (fire && cmd_r == pfa_pkg::CMD_ALLOC) begin
      if (final_r) begin
        ptr_r   <= '0;
        tally_r <= '0;
      end else begin
        tally_r <= tally_nxt;
        if (found_r) begin
          ptr_r <= pick_r;
        end
      end
    end
  end

  // Output register
  logic                              out_granted_r;
  logic [pfa_pkg::IDX_FIELD_W-1:0]   out_chosen_r;
  logic [pfa_pkg::AMT_W-1:0]         out_left_r;
  logic [pfa_pkg::FREE_W-1:0]        out_free_r;
  logic [pfa_pkg::TALLY_W-1:0]       out_tally_r;
  logic [pfa_pkg::FRAG_W-1:0]        out_frag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_granted_r <= granted;
      out_free_r    <= free_sat;
      out_tally_r   <= tally_nxt;
      out_frag_r    <= frag;
      if (cmd_r == pfa_pkg::CMD_LOAD) begin
        out_chosen_r <= bidx_r;
        out_left_r   <= load_left_r;
      end else if (found_r) begin
        out_chosen_r <= pfa_pkg::IDX_FIELD_W'(pick_r);
        out_left_r   <= rem_wide[pfa_pkg::AMT_W-1:0];
      end else begin
        out_chosen_r <= '0;
        out_left_r   <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_granted_r;
  assign out_tdata  = {6'd0, out_frag_r, out_tally_r, out_free_r, out_left_r, out_chosen_r};

endmodule

`default_nettype wire

// ===== rtl/pfa_checker.sv =====
`default_nettype none

module pfa_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire [pfa_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire                             out_tuser,
  input wire                             out_tvalid,
  input wire                             out_tready
);

  logic [pfa_pkg::AMT_W-1:0]   left;
  logic [pfa_pkg::FREE_W-1:0]  free;
  logic [pfa_pkg::TALLY_W-1:0] tally;
  logic [pfa_pkg::FRAG_W-1:0]  frag;

  assign left  = out_tdata[19:4];
  assign free  = out_tdata[39:20];
  assign tally = out_tdata[63:40];
  assign frag  = out_tdata[65:64];

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the block works on one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted during a scan");

  // verdict is zero exactly when nothing is unplaced, and a known code
  a_frag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((frag == pfa_pkg::FRAG_NONE) == (tally == '0)) &&
                   (frag == pfa_pkg::FRAG_NONE || frag == pfa_pkg::FRAG_EXTERNAL ||
                    frag == pfa_pkg::FRAG_SHORT))
    else $error("fragmentation verdict disagrees with tally");

  // a granted partition is part of the free space
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> 20'(left) <= free)
    else $error("block remainder exceeds total free space");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
